>>> rtl/qft_pkg.sv
package qft_pkg;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_QUERY     = 2'd1,
    OP_RECONNECT = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    RC_UP        = 2'd0,
    RC_TRANSPORT = 2'd1,
    RC_AUTH      = 2'd2
  } outcome_t;

  typedef enum logic [2:0] {
    FS_UNKNOWN      = 3'd0,
    FS_LIVE         = 3'd1,
    FS_STALE        = 3'd2,
    FS_DELAYED      = 3'd3,
    FS_DISCONNECTED = 3'd4
  } feed_state_t;

  typedef enum logic [1:0] {
    ERR_NONE            = 2'd0,
    ERR_DATA_STALE      = 2'd1,
    ERR_SESSION_EXPIRED = 2'd2
  } err_t;

  typedef enum logic [0:0] {
    REG_STALE_LIMIT = 1'b0,
    REG_DELAY_LIMIT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_RESOLVE
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic evaluate;
    logic commit;
  } qft_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } qft_stat_t;

  typedef struct packed {
    logic        seen;
    logic [31:0] price;
    logic [62:0] xtime;
    logic [62:0] rtime;
  } entry_t;

endpackage

>>> rtl/qft_ctrl.sv
module qft_ctrl
  import qft_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  qft_stat_t stat,
  output qft_cmd_t  cmd,
  output logic      in_stall
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.evaluate = 1'b1;
        state_next   = S_RESOLVE;
      end
      S_RESOLVE: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

endmodule

>>> rtl/qft_dp.sv
module qft_dp
  import qft_pkg::*;
#(
  parameter int SYMBOL_SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [1:0]  op,
  input  logic [7:0]  symbol_index,
  input  logic [31:0] tick_price,
  input  logic [62:0] tick_exchange_time,
  input  logic [62:0] now_local,
  input  logic [62:0] wall_time,
  input  logic [1:0]  reconnect_outcome,
  input  qft_cmd_t    cmd,
  output qft_stat_t   stat,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  feed_state,
  output logic        tradable,
  output logic        price_valid,
  output logic [31:0] last_price,
  output logic [1:0]  error_code,
  output logic        alert_raised,
  output logic        tick_accepted
);

  localparam int IDX_W = $clog2(SYMBOL_SLOTS);
  localparam int EXT_W = IDX_W + 8;

  function automatic logic exceeds(logic [62:0] now_t, logic [62:0] then_t,
                                   logic [31:0] limit);
    logic [63:0] diff;
    diff = {1'b0, now_t} - {1'b0, then_t};
    return !diff[63] && (diff[62:0] > {31'b0, limit});
  endfunction

  logic [31:0] stale_limit;
  logic [31:0] delay_limit;
  logic        link_up;
  logic        link_up_next;
  logic [IDX_W-1:0] clr_addr;

  entry_t mem [SYMBOL_SLOTS];
  entry_t rd_q;

  logic [EXT_W-1:0] slot_ext;
  logic [IDX_W-1:0] slot_in;
  logic             range_in;

  logic [1:0]       op_q;
  logic [IDX_W-1:0] slot_q;
  logic             range_q;
  logic [31:0]      price_q;
  logic [62:0]      xtime_q;
  logic [62:0]      nlocal_q;
  logic [62:0]      nwall_q;
  logic [1:0]       outcome_q;

  logic seen_q;
  logic newer_q;
  logic stale_q;
  logic delay_q;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;

  feed_state_t r_fs;
  logic        r_tradable;
  logic        r_pv;
  logic [31:0] r_price;
  err_t        r_err;
  logic        r_alert;
  logic        tick_write;

  assign slot_ext = {{IDX_W{1'b0}}, symbol_index};
  assign slot_in  = slot_ext[IDX_W-1:0];
  assign range_in = slot_ext < EXT_W'(SYMBOL_SLOTS);

  assign stat.clr_last = (clr_addr == IDX_W'(SYMBOL_SLOTS - 1));
  assign stat.out_free = !out_valid || !out_stall;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stale_limit <= '0;
      delay_limit <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_STALE_LIMIT: stale_limit <= cfg_data;
        REG_DELAY_LIMIT: delay_limit <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q      <= op;
      slot_q    <= slot_in;
      range_q   <= range_in;
      price_q   <= tick_price;
      xtime_q   <= tick_exchange_time;
      nlocal_q  <= now_local;
      nwall_q   <= wall_time;
      outcome_q <= reconnect_outcome;
    end
  end

  // table
  always_comb begin
    mem_we    = cmd.clr_step || (cmd.commit && tick_write);
    mem_waddr = cmd.clr_step ? clr_addr : slot_q;
    if (cmd.clr_step) begin
      mem_wdata = '0;
    end else begin
      mem_wdata.seen  = 1'b1;
      mem_wdata.price = price_q;
      mem_wdata.xtime = xtime_q;
      mem_wdata.rtime = nlocal_q;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.accept) begin
      rd_q <= mem[slot_in];
    end
  end

  // compare stage
  always_ff @(posedge clk) begin
    if (cmd.evaluate) begin
      seen_q  <= range_q && rd_q.seen;
      newer_q <= xtime_q > rd_q.xtime;
      stale_q <= exceeds(nlocal_q, rd_q.rtime, stale_limit);
      delay_q <= exceeds(nwall_q, rd_q.xtime, delay_limit);
    end
  end

  // result
  always_comb begin
    r_fs         = FS_UNKNOWN;
    r_tradable   = 1'b0;
    r_pv         = 1'b0;
    r_price      = '0;
    r_err        = ERR_NONE;
    r_alert      = 1'b0;
    tick_write   = 1'b0;
    link_up_next = link_up;
    unique case (op_q)
      OP_TICK: begin
        tick_write = range_q && (!seen_q || newer_q);
      end
      OP_QUERY: begin
        priority if (!link_up) begin
          r_fs = FS_DISCONNECTED;
        end else if (!seen_q) begin
          r_fs = FS_UNKNOWN;
        end else if (stale_q) begin
          r_fs = FS_STALE;
        end else if (delay_q) begin
          r_fs = FS_DELAYED;
        end else begin
          r_fs = FS_LIVE;
        end
        r_tradable = (r_fs == FS_LIVE);
        r_pv       = seen_q;
        r_price    = seen_q ? rd_q.price : '0;
        r_err      = (r_fs == FS_LIVE) ? ERR_NONE : ERR_DATA_STALE;
      end
      OP_RECONNECT: begin
        unique case (outcome_q)
          RC_UP:        link_up_next = 1'b1;
          RC_TRANSPORT: link_up_next = 1'b0;
          RC_AUTH: begin
            link_up_next = 1'b0;
            r_err        = ERR_SESSION_EXPIRED;
            r_alert      = 1'b1;
          end
          default: link_up_next = link_up;
        endcase
      end
      default: tick_write = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_up   <= 1'b0;
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      link_up   <= link_up_next;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      feed_state    <= r_fs;
      tradable      <= r_tradable;
      price_valid   <= r_pv;
      last_price    <= r_price;
      error_code    <= r_err;
      alert_raised  <= r_alert;
      tick_accepted <= tick_write;
    end
  end

endmodule

>>> rtl/quote_freshness_table.sv
// channel  signals                                   beat when
// in       op symbol_index tick_price                in_valid && !in_stall
//          tick_exchange_time now_local wall_time
//          reconnect_outcome
// out      feed_state tradable price_valid           out_valid && !out_stall
//          last_price error_code alert_raised
//          tick_accepted
// cfg      cfg_index cfg_data                        cfg_we
//
// one item at a time: accept with table read, then compare, then commit;
// the table is read-modify-written through one registered read port
// reset starts a clearing pass over all SYMBOL_SLOTS table entries, in_stall high
// the output register holds the result while the next item is accepted
// a stalled output holds commit, and the table write with it, until the slot frees
module quote_freshness_table
  import qft_pkg::*;
#(
  parameter int SYMBOL_SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  symbol_index,
  input  logic [31:0] tick_price,
  input  logic [62:0] tick_exchange_time,
  input  logic [62:0] now_local,
  input  logic [62:0] wall_time,
  input  logic [1:0]  reconnect_outcome,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  feed_state,
  output logic        tradable,
  output logic        price_valid,
  output logic [31:0] last_price,
  output logic [1:0]  error_code,
  output logic        alert_raised,
  output logic        tick_accepted
);

  qft_cmd_t  cmd;
  qft_stat_t stat;

  qft_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  qft_dp #(
    .SYMBOL_SLOTS (SYMBOL_SLOTS)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .op                 (op),
    .symbol_index       (symbol_index),
    .tick_price         (tick_price),
    .tick_exchange_time (tick_exchange_time),
    .now_local          (now_local),
    .wall_time          (wall_time),
    .reconnect_outcome  (reconnect_outcome),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .feed_state         (feed_state),
    .tradable           (tradable),
    .price_valid        (price_valid),
    .last_price         (last_price),
    .error_code         (error_code),
    .alert_raised       (alert_raised),
    .tick_accepted      (tick_accepted)
  );

  a_clear_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input open right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second beat taken while an item is in flight");

  a_tradable_live: assert property (@(posedge clk) disable iff (rst)
    (out_valid && tradable) |-> (feed_state == FS_LIVE && error_code == ERR_NONE))
    else $error("tradable result not live");

  a_alert_session: assert property (@(posedge clk) disable iff (rst)
    (out_valid && alert_raised) |->
      (error_code == ERR_SESSION_EXPIRED && !price_valid && !tick_accepted))
    else $error("alert without session expired");

endmodule
